// ===== sv/kruskal_minimum_spanning_tree_defines.svh =====
// ----------------------------------------------------------------------------
// kruskal minimum spanning tree assertion macros
// shared property shorthands for the spanning tree engine
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_MINIMUM_SPANNING_TREE_DEFINES_SVH
`define KRUSKAL_MINIMUM_SPANNING_TREE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define KMST_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define KMST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kmst_pkg.sv =====
// ----------------------------------------------------------------------------
// kmst_pkg
// types, widths and defaults of the spanning tree engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kmst_pkg;

  localparam int VERT_W       = 6;
  localparam int WEIGHT_W     = 16;
  localparam int VCNT_W       = 7;
  localparam int DEF_MAX_VERT = 64;
  localparam int DEF_MAX_EDGE = 256;
  localparam int DEF_WBITS    = 16;
  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

  // one loaded edge
  typedef struct packed {
    logic [VERT_W-1:0]   edge_src;
    logic [VERT_W-1:0]   edge_dest;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                edge_last;
  } in_t;

  // one result beat
  typedef struct packed {
    logic [VERT_W-1:0]   tree_src;
    logic [VERT_W-1:0]   tree_dest;
    logic [WEIGHT_W-1:0] tree_weight;
    logic                edge_valid;
    logic [VERT_W-1:0]   tree_count;
    logic                overflow;
    logic                result_last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_FA,
    S_FB,
    S_UNITE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/kruskal_minimum_spanning_tree.sv =====
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree
// edge loader, stable weight ordering and union-find tree builder
// ----------------------------------------------------------------------------
// Edges load one per cycle while busy is low. The beat with edge_last set
// raises busy and starts the run. Each pass scans the edge store once, one
// entry per cycle, to find the next edge in (weight, load order). A chosen
// edge with both vertices in range then walks both roots over the parent
// memory, and S_UNITE joins the two trees if the roots differ. There are at
// most edges_loaded + 1 passes. Passes stop once vertex_count-1 edges are
// taken or no edge is left, and S_DONE then gives the final beat. Results
// appear on out_data for one cycle each with out_valid. The receiver cannot
// stall, so it must take every beat. The final beat has result_last set. An
// empty tree gives one beat with edge_valid low. cfg_ready is low while busy,
// so vertex_count only changes between runs. The parent memory is cleared at
// once by valid bits, so no clearing pass is needed between graphs.
`timescale 1ns / 1ps
`default_nettype none
`include "kruskal_minimum_spanning_tree_defines.svh"
module kruskal_minimum_spanning_tree
  import kmst_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERT,
  parameter int MAX_EDGES    = DEF_MAX_EDGE,
  parameter int WEIGHT_BITS  = DEF_WBITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_t               in_data,
  output logic                   out_valid,
  output out_t                   out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [VCNT_W-1:0] cfg_data
);

  localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] EDGE_CAP = CW'(MAX_EDGES);
  localparam logic [SW-1:0] STEP_CAP = SW'(MAX_VERTICES);
  localparam logic [VCNT_W-1:0] VMAX = VCNT_W'(MAX_VERTICES);
  localparam logic [WEIGHT_W-1:0] WMASK = (WEIGHT_BITS >= WEIGHT_W) ?
      {WEIGHT_W{1'b1}} : WEIGHT_W'((1 << WEIGHT_BITS) - 1);
  localparam int EW = 2 * VERT_W + WEIGHT_W;

  // memories
  logic [EW-1:0] edge_mem [MAX_EDGES];
  logic [VW-1:0] par_mem  [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] par_vld_r;

  state_t state_r, state_nxt;
  logic [VCNT_W-1:0] vcnt_r;
  logic [CW-1:0] loaded_r, loaded_nxt;
  logic ovf_r, ovf_nxt;
  logic [VERT_W-1:0] acc_r, acc_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic rd_v_r, rd_v_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [EW-1:0] ed_q;
  logic have_prev_r, have_prev_nxt;
  logic [WEIGHT_W-1:0] prev_w_r, prev_w_nxt;
  logic [IW-1:0] prev_idx_r, prev_idx_nxt;
  logic best_v_r, best_v_nxt;
  logic [WEIGHT_W-1:0] best_w_r, best_w_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [VERT_W-1:0] best_s_r, best_s_nxt, best_d_r, best_d_nxt;
  logic [VW-1:0] cur_r, cur_nxt, ra_r, ra_nxt, rb_r, rb_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic side_r, side_nxt;
  logic pend_v_r, pend_v_nxt;
  out_t pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;
  logic [VW-1:0] par_q, par_raddr, p_val;
  logic par_vq, par_we, par_clr;
  logic [IW-1:0] ed_raddr;
  logic ed_we;

  logic [VCNT_W-1:0] nv;
  logic [VERT_W-1:0] limit;
  logic [VERT_W-1:0] e_s, e_d;
  logic [WEIGHT_W-1:0] e_w;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // clamped vertex count and edge limit
  always_comb begin
    if (vcnt_r == '0) nv = VCNT_W'(1);
    else if (vcnt_r > VMAX) nv = VMAX;
    else nv = vcnt_r;
    limit = VERT_W'(nv - VCNT_W'(1));
  end

  assign {e_s, e_d, e_w} = ed_q;
  assign p_val = par_vq ? par_q : cur_r;

  // edge store
  always_ff @(posedge clk) begin
    if (ed_we) edge_mem[loaded_r[IW-1:0]] <= {in_data.edge_src, in_data.edge_dest,
                                               in_data.edge_weight & WMASK};
    ed_q <= edge_mem[ed_raddr];
  end

  // parent store
  always_ff @(posedge clk) begin
    if (par_we) par_mem[ra_r] <= rb_r;
    par_q  <= par_mem[par_raddr];
    par_vq <= par_vld_r[par_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcnt_r      <= VCNT_RESET;
      loaded_r    <= '0;
      ovf_r       <= 1'b0;
      acc_r       <= '0;
      rd_v_r      <= 1'b0;
      have_prev_r <= 1'b0;
      best_v_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      par_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      ovf_r       <= ovf_nxt;
      acc_r       <= acc_nxt;
      rd_v_r      <= rd_v_nxt;
      have_prev_r <= have_prev_nxt;
      best_v_r    <= best_v_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) vcnt_r <= cfg_data;
      if (par_clr) par_vld_r <= '0;
      else if (par_we) par_vld_r[ra_r] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    rd_idx_r   <= rd_idx_nxt;
    prev_w_r   <= prev_w_nxt;
    prev_idx_r <= prev_idx_nxt;
    best_w_r   <= best_w_nxt;
    best_idx_r <= best_idx_nxt;
    best_s_r   <= best_s_nxt;
    best_d_r   <= best_d_nxt;
    cur_r      <= cur_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    steps_r    <= steps_nxt;
    side_r     <= side_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    ovf_nxt       = ovf_r;
    acc_nxt       = acc_r;
    scan_nxt      = scan_r;
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    have_prev_nxt = have_prev_r;
    prev_w_nxt    = prev_w_r;
    prev_idx_nxt  = prev_idx_r;
    best_v_nxt    = best_v_r;
    best_w_nxt    = best_w_r;
    best_idx_nxt  = best_idx_r;
    best_s_nxt    = best_s_r;
    best_d_nxt    = best_d_r;
    cur_nxt       = cur_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    steps_nxt     = steps_r;
    side_nxt      = side_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ed_we         = 1'b0;
    ed_raddr      = scan_r[IW-1:0];
    par_raddr     = cur_r;
    par_we        = 1'b0;
    par_clr       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (loaded_r < EDGE_CAP) begin
            ed_we      = 1'b1;
            loaded_nxt = loaded_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.edge_last) begin
            have_prev_nxt = 1'b0;
            best_v_nxt    = 1'b0;
            scan_nxt      = '0;
            pend_v_nxt    = 1'b0;
            state_nxt     = (limit == '0) ? S_DONE : S_SCAN;
          end
        end
      end

      // one pass over the store, one entry per cycle
      S_SCAN: begin
        if (scan_r < loaded_r) begin
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = scan_r[IW-1:0];
          scan_nxt   = scan_r + CW'(1);
        end else if (!rd_v_r) begin
          state_nxt = S_EVAL;
        end
        if (rd_v_r) begin
          if ((!have_prev_r || e_w > prev_w_r ||
               (e_w == prev_w_r && rd_idx_r > prev_idx_r)) &&
              (!best_v_r || e_w < best_w_r)) begin
            best_v_nxt   = 1'b1;
            best_w_nxt   = e_w;
            best_idx_nxt = rd_idx_r;
            best_s_nxt   = e_s;
            best_d_nxt   = e_d;
          end
        end
      end

      S_EVAL: begin
        if (!best_v_r) begin
          state_nxt = S_DONE;
        end else if (VCNT_W'(best_s_r) >= nv || VCNT_W'(best_d_r) >= nv) begin
          have_prev_nxt = 1'b1;
          prev_w_nxt    = best_w_r;
          prev_idx_nxt  = best_idx_r;
          best_v_nxt    = 1'b0;
          scan_nxt      = '0;
          state_nxt     = S_SCAN;
        end else begin
          cur_nxt   = best_s_r[VW-1:0];
          side_nxt  = 1'b0;
          steps_nxt = '0;
          state_nxt = S_FA;
        end
      end

      // root walk: address then compare
      S_FA: begin
        state_nxt = S_FB;
      end

      S_FB: begin
        if (p_val == cur_r || steps_r == STEP_CAP) begin
          if (!side_r) begin
            ra_nxt    = cur_r;
            cur_nxt   = best_d_r[VW-1:0];
            side_nxt  = 1'b1;
            steps_nxt = '0;
            state_nxt = S_FA;
          end else begin
            rb_nxt    = cur_r;
            state_nxt = S_UNITE;
          end
        end else begin
          cur_nxt   = p_val;
          steps_nxt = steps_r + SW'(1);
          state_nxt = S_FA;
        end
      end

      S_UNITE: begin
        have_prev_nxt = 1'b1;
        prev_w_nxt    = best_w_r;
        prev_idx_nxt  = best_idx_r;
        best_v_nxt    = 1'b0;
        scan_nxt      = '0;
        state_nxt     = S_SCAN;
        if (ra_r != rb_r) begin
          par_we  = 1'b1;
          acc_nxt = acc_r + VERT_W'(1);
          if (pend_v_r) begin
            out_valid_nxt        = 1'b1;
            out_nxt              = pend_r;
            out_nxt.overflow     = ovf_r;
            out_nxt.result_last  = 1'b0;
          end
          pend_v_nxt           = 1'b1;
          pend_nxt.tree_src    = best_s_r;
          pend_nxt.tree_dest   = best_d_r;
          pend_nxt.tree_weight = best_w_r;
          pend_nxt.edge_valid  = 1'b1;
          pend_nxt.tree_count  = acc_r + VERT_W'(1);
          pend_nxt.overflow    = ovf_r;
          pend_nxt.result_last = 1'b0;
          if (acc_r + VERT_W'(1) == limit) state_nxt = S_DONE;
        end
      end

      // final beat and clear for the next graph
      S_DONE: begin
        out_valid_nxt = 1'b1;
        if (pend_v_r) begin
          out_nxt = pend_r;
        end else begin
          out_nxt = '0;
        end
        out_nxt.overflow    = ovf_r;
        out_nxt.result_last = 1'b1;
        pend_v_nxt = 1'b0;
        loaded_nxt = '0;
        ovf_nxt    = 1'b0;
        acc_nxt    = '0;
        par_clr    = 1'b1;
        state_nxt  = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // checks
  `KMST_NEXT(a_last_ends, out_valid && out_data.result_last, !out_valid, "beat after last")
  `KMST_IMPLY(a_empty_last, out_valid && !out_data.edge_valid, out_data.result_last, "empty not last")
  `KMST_IMPLY(a_cnt_valid, out_valid, out_data.edge_valid == (out_data.tree_count != '0), "count mismatch")
  `KMST_IMPLY(a_idle_clear, !busy, acc_r == '0 && !pend_v_r, "stale run state")

endmodule
`default_nettype wire

// ===== tb/kruskal_minimum_spanning_tree_test.sv =====
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_test
// loads graphs edge by edge, predicts the spanning tree beats and checks them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kruskal_minimum_spanning_tree_test;
  import kmst_pkg::*;

  localparam int STORE_DEPTH = 256;
  localparam int NVERT       = 64;
  localparam int IDLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [VCNT_W-1:0] cfg_data = '0;

  kruskal_minimum_spanning_tree uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  in_t              graph_edges[STORE_DEPTH];
  int               graph_len;
  logic             graph_dropped;
  logic [VCNT_W-1:0] vcount_reg;
  out_t             tree_beats[$];
  int               mismatch_count;
  int               idle_cycles;
  logic             quiet_tail;

  // directed table: rows with a typed result use has_pin
  typedef struct {
    in_t  beat;
    logic has_pin;
    out_t pin;
  } dir_row_t;

  function automatic int find_root(ref logic [5:0] par[NVERT], input int v);
    int hops;
    hops = 0;
    while (par[v] != v && hops < NVERT) begin
      v = par[v];
      hops++;
    end
    return v;
  endfunction

  // store an edge; on a last edge build the tree and queue its beats
  task automatic predict_tree(input in_t e);
    int order[STORE_DEPTH];
    logic [5:0] par[NVERT];
    int nv, lim, taken, j, ra, rb, cur;
    out_t r;
    if (graph_len < STORE_DEPTH) begin
      graph_edges[graph_len] = e;
      graph_len++;
    end else begin
      graph_dropped = 1'b1;
    end
    if (e.edge_last) begin
      nv = vcount_reg;
      if (nv < 1) nv = 1;
      if (nv > NVERT) nv = NVERT;
      lim = nv - 1;
      for (int v = 0; v < NVERT; v++) par[v] = 6'(v);
      // stable insertion sort by weight
      for (int i = 0; i < graph_len; i++) begin
        j = i;
        while (j > 0 && graph_edges[order[j-1]].edge_weight > graph_edges[i].edge_weight) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      taken = 0;
      for (int i = 0; i < graph_len && taken < lim; i++) begin
        cur = order[i];
        if (graph_edges[cur].edge_src >= nv || graph_edges[cur].edge_dest >= nv) continue;
        ra = find_root(par, graph_edges[cur].edge_src);
        rb = find_root(par, graph_edges[cur].edge_dest);
        if (ra == rb) continue;
        par[ra] = 6'(rb);
        taken++;
        r = '0;
        r.tree_src = graph_edges[cur].edge_src;
        r.tree_dest = graph_edges[cur].edge_dest;
        r.tree_weight = graph_edges[cur].edge_weight;
        r.edge_valid = 1'b1;
        r.tree_count = VERT_W'(taken);
        r.overflow = graph_dropped;
        tree_beats.push_back(r);
      end
      if (taken == 0) begin
        r = '0;
        r.overflow = graph_dropped;
        r.result_last = 1'b1;
        tree_beats.push_back(r);
      end else begin
        tree_beats[tree_beats.size()-1].result_last = 1'b1;
      end
      graph_len = 0;
      graph_dropped = 1'b0;
    end
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        if (tree_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected beat %p", out_data);
        end else begin
          if (out_data !== tree_beats[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch exp %p act %p", tree_beats[0], out_data);
          end
          void'(tree_beats.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // random pause of the sender, start dropped for its length
  task automatic idle_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // one edge beat, held until accepted; start stays up for the next beat
  task automatic send_edge(input in_t e);
    idle_gap();
    start <= 1'b1;
    in_data <= e;
    do @(posedge clk); while (busy);
    predict_tree(e);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tree_beats.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_vcount(input logic [VCNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    vcount_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t mk_edge(int s, int d, int w, bit l);
    in_t e;
    e.edge_src = VERT_W'(s);
    e.edge_dest = VERT_W'(d);
    e.edge_weight = WEIGHT_W'(w);
    e.edge_last = l;
    return e;
  endfunction

  function automatic out_t mk_beat(int s, int d, int w, bit v, int c, bit o, bit l);
    out_t r;
    r.tree_src = VERT_W'(s); r.tree_dest = VERT_W'(d); r.tree_weight = WEIGHT_W'(w);
    r.edge_valid = v; r.tree_count = VERT_W'(c); r.overflow = o; r.result_last = l;
    return r;
  endfunction

  initial begin
    dir_row_t rows[$];
    in_t e;
    int nedges, nv;
    mismatch_count = 0;
    idle_cycles = 0;
    quiet_tail = 1'b0;
    graph_len = 0;
    graph_dropped = 1'b0;
    vcount_reg = VCNT_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single edge, extremes, self loop, ties
    rows.push_back('{mk_edge(63, 0, 16'hffff, 1), 1, mk_beat(63, 0, 16'hffff, 1, 1, 0, 1)});
    rows.push_back('{mk_edge(5, 5, 0, 1), 1, mk_beat(0, 0, 0, 0, 0, 0, 1)});
    rows.push_back('{mk_edge(0, 1, 7, 0), 0, '0});
    rows.push_back('{mk_edge(1, 2, 7, 0), 0, '0});
    rows.push_back('{mk_edge(0, 2, 7, 0), 0, '0});
    rows.push_back('{mk_edge(2, 3, 0, 0), 0, '0});
    rows.push_back('{mk_edge(3, 0, 16'hffff, 1), 0, '0});
    foreach (rows[i]) begin
      send_edge(rows[i].beat);
      if (rows[i].has_pin) begin
        tree_beats[tree_beats.size()-1] = rows[i].pin;
      end
    end
    // vertex count extremes
    write_vcount(1);
    send_edge(mk_edge(0, 1, 3, 0));
    send_edge(mk_edge(0, 0, 3, 1));
    write_vcount(0);
    send_edge(mk_edge(0, 1, 1, 1));
    write_vcount(7'h7f);
    send_edge(mk_edge(62, 63, 9, 0));
    send_edge(mk_edge(3, 9, 9, 1));
    write_vcount(2);
    send_edge(mk_edge(0, 2, 1, 0));
    send_edge(mk_edge(1, 0, 4, 1));
    write_vcount(64);
    drain();

    // random graphs, mostly small, vertex count varied
    for (int g = 0; g < 24; g++) begin
      if (g == 18) quiet_tail = 1'b1;
      if (g % 4 == 0)
        write_vcount($urandom_range(0, 3) == 0 ? VCNT_W'($urandom) :
                     VCNT_W'($urandom_range(2, 12)));
      nv = vcount_reg == 0 ? 1 : (vcount_reg > 64 ? 64 : vcount_reg);
      nedges = $urandom_range(1, 8);
      for (int i = 0; i < nedges; i++) begin
        e = mk_edge(0, 0, 0, i == nedges - 1);
        if ($urandom_range(0, 7) == 0) begin
          e.edge_src = VERT_W'($urandom); e.edge_dest = VERT_W'($urandom);
        end else begin
          e.edge_src = VERT_W'($urandom_range(0, nv - 1));
          e.edge_dest = VERT_W'($urandom_range(0, nv - 1));
        end
        e.edge_weight = $urandom_range(0, 1) ? WEIGHT_W'($urandom_range(0, 4)) :
                        WEIGHT_W'($urandom);
        send_edge(e);
      end
    end

    drain();
    if (mismatch_count == 0 && tree_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
